@@ rtl/core/astn_pkg.sv @@
// Package for the assembly source text normaliser.
// Item types, scan mode codes, result kinds and character constants; no dependencies.
package astn_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] result_kind;
        logic       last;
    } t_out_item;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_SPACE   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_NEWLINE = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // result queue depth and its pointer width
    localparam int unsigned QDEPTH = 3;
    localparam int unsigned QPW    = 2;

endpackage

@@ rtl/core/assembly_source_text_normalizer_core.sv @@
// Assembly source text normaliser core: scan state machine and result queue.
// Depends on astn_pkg.
//
// Takes one source byte per item and gives the normalised text as result items
// (character, invalid-character error, or end of text), each flagged last on the
// final result of its item. An item is taken in a cycle in which it is offered and the
// input does not stall; its zero, one or two results are written straight into a
// three-entry result queue, and the first result can leave on the next cycle. The input
// stalls while the queue holds two or more results, so a steady stream runs at one item
// per cycle while the receiver does not stall, and each item that yields two results (a
// pending space or newline ahead of a character or an invalid byte, or a newline still
// pending at the end of text) stalls the input behind it.
module assembly_source_text_normalizer_core
    import astn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    function automatic logic [QPW-1:0] f_inc(input logic [QPW-1:0] p);
        f_inc = (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [2:0]     r_mode, n_mode;
    logic           r_start, n_start;
    t_out_item      r_queue [QDEPTH];
    logic [QPW-1:0] r_rd, r_wr;
    logic [1:0]     r_count, n_count;

    logic       w_acc, w_pop;
    logic [7:0] w_ch;
    logic       w_blank, w_word;

    // first-step bookkeeping: optional pending space/newline, then the plain scan
    logic       w_pre;
    logic [7:0] w_pre_char;
    logic       w_take;
    logic       w_take_start;
    logic       w_tn_emit;
    logic [7:0] w_tn_char;
    logic [1:0] w_tn_kind;
    logic [2:0] w_tn_mode;
    logic       w_tn_start;
    logic       w_end_nl;

    t_out_item  w_res0, w_res1;
    logic [1:0] w_push;

    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_pop       = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_count > 2'd1);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out       = r_queue[r_rd];

    assign w_ch    = i_in.text_byte;
    assign w_blank = (w_ch == CH_SPACE) || (w_ch == CH_TAB);
    assign w_word  = ((w_ch >= CH_LO_A) && (w_ch <= CH_LO_Z))
                  || ((w_ch >= CH_UP_A) && (w_ch <= CH_UP_Z))
                  || ((w_ch >= CH_DIG_0) && (w_ch <= CH_DIG_9))
                  || (w_ch == CH_UNDER) || (w_ch == CH_COLON)
                  || (w_ch == CH_DOT) || (w_ch == CH_COMMA);

    // scan of a character with nothing pending
    always_comb begin
        w_tn_emit  = 1'b0;
        w_tn_char  = CH_NUL;
        w_tn_kind  = KIND_CHAR;
        w_tn_mode  = MODE_NORMAL;
        w_tn_start = w_take_start;
        if (w_blank) begin
            w_tn_mode = w_take_start ? MODE_NORMAL : MODE_SPACE;
        end else if (w_ch == CH_NL) begin
            w_tn_mode = MODE_NEWLINE;
        end else if (w_ch == CH_SEMI) begin
            w_tn_mode = MODE_COMMENT;
        end else if (w_word) begin
            w_tn_emit  = 1'b1;
            w_tn_char  = ((w_ch >= CH_UP_A) && (w_ch <= CH_UP_Z)) ? w_ch + CASE_OFS : w_ch;
            w_tn_start = 1'b0;
        end else begin
            w_tn_emit = 1'b1;
            w_tn_kind = KIND_ERROR;
            w_tn_mode = MODE_ERROR;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_start      = r_start;
        w_pre        = 1'b0;
        w_pre_char   = CH_NUL;
        w_take       = 1'b0;
        w_take_start = r_start;
        w_end_nl     = (r_mode == MODE_NEWLINE) && !r_start;
        if (i_in.end_of_text) begin
            n_mode  = MODE_NORMAL;
            n_start = 1'b1;
        end else if (w_ch != CH_NUL) begin
            case (r_mode)
                MODE_ERROR: begin
                end
                MODE_COMMENT: begin
                    if (w_ch == CH_NL) n_mode = MODE_NEWLINE;
                end
                MODE_NEWLINE: begin
                    if (w_ch == CH_NL || w_blank) begin
                    end else if (w_ch == CH_SEMI) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        w_pre        = !r_start;
                        w_pre_char   = CH_NL;
                        w_take       = 1'b1;
                        w_take_start = 1'b0;
                    end
                end
                MODE_SPACE: begin
                    if (w_blank) begin
                    end else if (w_ch == CH_NL) begin
                        n_mode = MODE_NEWLINE;
                    end else if (w_ch == CH_SEMI) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        w_pre      = 1'b1;
                        w_pre_char = CH_SPACE;
                        w_take     = 1'b1;
                    end
                end
                MODE_NORMAL: begin
                    w_take = 1'b1;
                end
                default: begin
                    n_mode = MODE_ERROR;
                end
            endcase
            if (w_take) begin
                n_mode  = w_tn_mode;
                n_start = w_tn_start;
            end
        end
    end

    // pack the results of this item into queue order
    always_comb begin
        w_res0 = '{out_char: CH_NUL, result_kind: KIND_CHAR, last: 1'b1};
        w_res1 = '{out_char: CH_NUL, result_kind: KIND_CHAR, last: 1'b1};
        w_push = 2'd0;
        if (i_in.end_of_text) begin
            if (w_end_nl) begin
                w_res0 = '{out_char: CH_NL, result_kind: KIND_CHAR, last: 1'b0};
                w_res1 = '{out_char: CH_NUL, result_kind: KIND_END, last: 1'b1};
                w_push = 2'd2;
            end else begin
                w_res0 = '{out_char: CH_NUL, result_kind: KIND_END, last: 1'b1};
                w_push = 2'd1;
            end
        end else begin
            if (w_pre) begin
                w_res0 = '{out_char: w_pre_char, result_kind: KIND_CHAR,
                           last: !(w_take && w_tn_emit)};
                w_res1 = '{out_char: w_tn_char, result_kind: w_tn_kind, last: 1'b1};
                w_push = (w_take && w_tn_emit) ? 2'd2 : 2'd1;
            end else if (w_take && w_tn_emit) begin
                w_res0 = '{out_char: w_tn_char, result_kind: w_tn_kind, last: 1'b1};
                w_push = 2'd1;
            end
        end
    end

    assign n_count = r_count + (w_acc ? w_push : 2'd0) - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_start <= 1'b1;
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_pop) r_rd <= f_inc(r_rd);
            if (w_acc) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                case (w_push)
                    2'd1: r_wr <= f_inc(r_wr);
                    2'd2: r_wr <= f_inc(f_inc(r_wr));
                    default: r_wr <= r_wr;
                endcase
            end
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_push != 2'd0)) begin
            r_queue[r_wr] <= w_res0;
            if (w_push == 2'd2) r_queue[f_inc(r_wr)] <= w_res1;
        end
    end

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd3) ? (r_wr == r_rd)
        : ((r_count == 2'd0) ? (r_wr == r_rd)
        : ((r_count == 2'd1) ? (r_wr == f_inc(r_rd)) : (r_wr == f_inc(f_inc(r_rd))))))
        else $error("result queue pointers disagree with count");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.end_of_text) |=> (r_mode == MODE_NORMAL) && r_start)
        else $error("scan state not restored after end of text");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ERROR && !(w_acc && i_in.end_of_text)) |=> (r_mode == MODE_ERROR))
        else $error("error mode left before end of text");

    a_space_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SPACE) |-> !r_start)
        else $error("space run pending at text start");

endmodule

@@ tb/sv/tb_assembly_source_text_normalizer_core.sv @@
// Testbench for assembly_source_text_normalizer_core: directed rows, then random source texts.
// Expected results come from an in-bench model of the scanner; depends on astn_pkg and the core.
module tb_assembly_source_text_normalizer_core;
    import astn_pkg::*;

    localparam int ITEM_TARGET    = 1650;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int FROM_PREDICTOR = -1;

    typedef struct {
        t_in_item  stim;
        int        n_typed;
        t_out_item e0;
        t_out_item e1;
    } t_row;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // model state
    logic [2:0] text_mode = MODE_NORMAL;
    bit         fresh_text = 1'b1;

    t_out_item norm_due_q[$];
    t_in_item  text_buf[$];
    t_row      dir_rows[$];

    int  fails = 0;
    int  items_sent = 0;
    int  texts_sent = 0;
    int  results_seen = 0;
    int  errors_seen = 0;
    int  ends_seen = 0;
    int  burst_left = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    assembly_source_text_normalizer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    function automatic t_out_item res_item(logic [7:0] c, logic [1:0] k, logic l);
        t_out_item v;
        v.out_char    = c;
        v.result_kind = k;
        v.last        = l;
        return v;
    endfunction

    function automatic bit word_char(logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_DIG_0 && c <= CH_DIG_9) || c == CH_UNDER || c == CH_COLON ||
               c == CH_DOT || c == CH_COMMA;
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    // One scanner step: returns the number of results and fills r
    function automatic int normalise_step(input t_in_item it, output t_out_item r [2]);
        int         n;
        logic [7:0] c;
        bit         take;
        n    = 0;
        c    = it.text_byte;
        take = 1'b0;
        r[0] = '0;
        r[1] = '0;
        if (it.end_of_text) begin
            if (text_mode == MODE_NEWLINE && !fresh_text) begin
                r[n] = res_item(CH_NL, KIND_CHAR, 1'b0);
                n++;
            end
            r[n] = res_item(CH_NUL, KIND_END, 1'b0);
            n++;
            text_mode  = MODE_NORMAL;
            fresh_text = 1'b1;
        end else if (c != CH_NUL) begin
            case (text_mode)
                MODE_ERROR: ;
                MODE_COMMENT: begin
                    if (c == CH_NL) text_mode = MODE_NEWLINE;
                end
                MODE_NEWLINE: begin
                    if (c == CH_NL || blank_char(c)) begin
                    end else if (c == CH_SEMI) begin
                        text_mode = MODE_COMMENT;
                    end else begin
                        if (fresh_text) begin
                            fresh_text = 1'b0;
                        end else begin
                            r[n] = res_item(CH_NL, KIND_CHAR, 1'b0);
                            n++;
                        end
                        text_mode = MODE_NORMAL;
                        take      = 1'b1;
                    end
                end
                MODE_SPACE: begin
                    if (blank_char(c)) begin
                    end else if (c == CH_NL) begin
                        text_mode = MODE_NEWLINE;
                    end else if (c == CH_SEMI) begin
                        text_mode = MODE_COMMENT;
                    end else begin
                        r[n] = res_item(CH_SPACE, KIND_CHAR, 1'b0);
                        n++;
                        text_mode = MODE_NORMAL;
                        take      = 1'b1;
                    end
                end
                MODE_NORMAL: take = 1'b1;
                default: text_mode = MODE_ERROR;
            endcase
            if (take) begin
                if (blank_char(c)) begin
                    if (!fresh_text) text_mode = MODE_SPACE;
                end else if (c == CH_NL) begin
                    text_mode = MODE_NEWLINE;
                end else if (c == CH_SEMI) begin
                    text_mode = MODE_COMMENT;
                end else if (word_char(c)) begin
                    if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;
                    r[n] = res_item(c, KIND_CHAR, 1'b0);
                    n++;
                    fresh_text = 1'b0;
                end else begin
                    r[n] = res_item(CH_NUL, KIND_ERROR, 1'b0);
                    n++;
                    text_mode = MODE_ERROR;
                end
            end
        end
        if (n > 0) r[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic void add_row(logic [7:0] b, logic eot, int n,
                                    t_out_item e0 = '0, t_out_item e1 = '0);
        t_row row;
        row.stim.text_byte   = b;
        row.stim.end_of_text = eot;
        row.n_typed          = n;
        row.e0               = e0;
        row.e1               = e1;
        dir_rows.push_back(row);
    endfunction

    // text building; an odd NUL is slipped in ahead of any byte
    function automatic void put(logic [7:0] c);
        t_in_item v;
        v.end_of_text = 1'b0;
        if ($urandom_range(0, 29) == 0) begin
            v.text_byte = CH_NUL;
            text_buf.push_back(v);
        end
        v.text_byte = c;
        text_buf.push_back(v);
    endfunction

    function automatic void put_blanks(int n);
        for (int k = 0; k < n; k++) put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void put_word(int len);
        logic [7:0] c;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
                0: c = CH_LO_A + 8'($urandom_range(0, 25));
                1: c = CH_UP_A + 8'($urandom_range(0, 25));
                2: c = CH_DIG_0 + 8'($urandom_range(0, 9));
                default: begin
                    case ($urandom_range(0, 3))
                        0: c = CH_UNDER;
                        1: c = CH_DOT;
                        2: c = CH_COLON;
                        default: c = CH_COMMA;
                    endcase
                end
            endcase
            put(c);
        end
    endfunction

    function automatic void put_comment();
        logic [7:0] c;
        put(CH_SEMI);
        repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
            put(c);
        end
    endfunction

    task automatic offer(input t_in_item it, input int n_typed = FROM_PREDICTOR,
                         input t_out_item e0 = '0, input t_out_item e1 = '0);
        int        gap;
        int        n;
        t_out_item got [2];
        gap = (tx_quiet || burst_left > 0) ? 0 : $urandom_range(0, 14);
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
        n = normalise_step(it, got);
        if (n_typed == FROM_PREDICTOR) begin
            for (int k = 0; k < n; k++) norm_due_q.push_back(got[k]);
        end else begin
            if (n_typed > 0) norm_due_q.push_back(e0);
            if (n_typed > 1) norm_due_q.push_back(e1);
        end
    endtask

    task automatic send_text();
        int         lines;
        int         sel;
        int         ops;
        logic [7:0] bad;
        t_in_item   v;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            // raw noise
            repeat ($urandom_range(0, 12)) put(8'($urandom_range(0, 255)));
        end else begin
            lines = $urandom_range(1, 6);
            for (int l = 0; l < lines; l++) begin
                sel = $urandom_range(0, 7);
                if (sel == 0) begin
                    put_blanks($urandom_range(0, 3));
                end else if (sel == 1) begin
                    put_blanks($urandom_range(0, 2));
                    put_comment();
                end else begin
                    put_blanks($urandom_range(0, 3));
                    if ($urandom_range(0, 2) == 0) begin
                        put_word($urandom_range(1, 6));
                        put(CH_COLON);
                        put_blanks($urandom_range(0, 2));
                    end
                    put_word($urandom_range(1, 5));
                    ops = $urandom_range(0, 3);
                    for (int o = 0; o < ops; o++) begin
                        if (o == 0) begin
                            put_blanks($urandom_range(1, 3));
                        end else begin
                            put_blanks($urandom_range(0, 1));
                            put(CH_COMMA);
                            put_blanks($urandom_range(0, 2));
                        end
                        put_word($urandom_range(1, 8));
                    end
                    put_blanks($urandom_range(0, 2));
                    if ($urandom_range(0, 3) == 0) put_comment();
                end
                if (l != lines - 1 || $urandom_range(0, 1))
                    repeat ($urandom_range(1, 2)) put(CH_NL);
            end
            if ($urandom_range(0, 5) == 0) begin
                do bad = 8'($urandom_range(1, 255));
                while (word_char(bad) || blank_char(bad) || bad == CH_NL || bad == CH_SEMI);
                v.text_byte   = bad;
                v.end_of_text = 1'b0;
                text_buf.insert($urandom_range(0, text_buf.size()), v);
            end
        end
        v.text_byte   = 8'($urandom_range(0, 255));
        v.end_of_text = 1'b1;
        text_buf.push_back(v);
        foreach (text_buf[i]) offer(text_buf[i]);
        texts_sent++;
    endtask

    // receiver: per-result stall draw, plus the long hold-off on request
    initial begin
        int wait_cyc;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            wait_cyc = rx_quiet ? 0 : $urandom_range(0, 14);
            if (wait_cyc > 0) begin
                out_stall = 1'b1;
                repeat (wait_cyc) @(negedge i_clk);
            end
            out_stall = 1'b0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    function automatic void report(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        fails++;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (out_item.result_kind == KIND_ERROR) errors_seen++;
            if (out_item.result_kind == KIND_END) ends_seen++;
            if (norm_due_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got char %0h kind %0d last %0d",
                         $time, out_item.out_char, out_item.result_kind, out_item.last);
                fails++;
            end else begin
                want = norm_due_q.pop_front();
                results_seen++;
                if (out_item.out_char !== want.out_char)
                    report("out_char", want.out_char, out_item.out_char);
                if (out_item.result_kind !== want.result_kind)
                    report("result_kind", 8'(want.result_kind), 8'(out_item.result_kind));
                if (out_item.last !== want.last)
                    report("last", 8'(want.last), 8'(out_item.last));
            end
        end
    end

    initial begin
        int drain;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        // text 1: every character class, runs, comments, pending space before a bad byte
        add_row(CH_SPACE, 1'b0, 0);
        add_row(CH_NL, 1'b0, 0);
        add_row(CH_UP_A, 1'b0, 1, res_item(CH_LO_A, KIND_CHAR, 1'b1));
        add_row(CH_UP_Z, 1'b0, 1, res_item(CH_LO_Z, KIND_CHAR, 1'b1));
        add_row(CH_TAB, 1'b0, FROM_PREDICTOR);
        add_row(CH_SPACE, 1'b0, FROM_PREDICTOR);
        add_row(CH_DIG_0, 1'b0, FROM_PREDICTOR);
        add_row(CH_DIG_9, 1'b0, FROM_PREDICTOR);
        add_row(CH_UNDER, 1'b0, FROM_PREDICTOR);
        add_row(CH_NUL, 1'b0, FROM_PREDICTOR);
        add_row(CH_COLON, 1'b0, FROM_PREDICTOR);
        add_row(CH_SPACE, 1'b0, FROM_PREDICTOR);
        add_row(CH_SEMI, 1'b0, FROM_PREDICTOR);
        add_row(CH_NL, 1'b0, FROM_PREDICTOR);
        add_row(CH_SEMI, 1'b0, FROM_PREDICTOR);
        add_row(CH_NL, 1'b0, FROM_PREDICTOR);
        add_row(CH_DOT, 1'b0, FROM_PREDICTOR);
        add_row(CH_COMMA, 1'b0, FROM_PREDICTOR);
        add_row(CH_SPACE, 1'b0, FROM_PREDICTOR);
        add_row(8'hFF, 1'b0, 2, res_item(CH_SPACE, KIND_CHAR, 1'b0),
                res_item(CH_NUL, KIND_ERROR, 1'b1));
        add_row("b", 1'b0, 0);
        add_row(8'hA5, 1'b1, 1, res_item(CH_NUL, KIND_END, 1'b1));
        // newline still pending at the end marker
        add_row(CH_LO_A, 1'b0, 1, res_item(CH_LO_A, KIND_CHAR, 1'b1));
        add_row(CH_NL, 1'b0, FROM_PREDICTOR);
        add_row(CH_NUL, 1'b1, 2, res_item(CH_NL, KIND_CHAR, 1'b0),
                res_item(CH_NUL, KIND_END, 1'b1));
        // trailing blanks, then a comment left open at the end
        add_row(CH_LO_Z, 1'b0, 1, res_item(CH_LO_Z, KIND_CHAR, 1'b1));
        add_row(CH_TAB, 1'b0, FROM_PREDICTOR);
        add_row(CH_SEMI, 1'b1, 1, res_item(CH_NUL, KIND_END, 1'b1));
        add_row(CH_SEMI, 1'b0, 0);
        add_row(CH_NUL, 1'b1, 1, res_item(CH_NUL, KIND_END, 1'b1));

        foreach (dir_rows[i])
            offer(dir_rows[i].stim, dir_rows[i].n_typed, dir_rows[i].e0, dir_rows[i].e1);

        while (items_sent < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if (texts_sent == 10 || texts_sent == 40) begin
                // long receiver hold while items keep coming back to back
                hold_req   = 1'b1;
                burst_left = 60;
            end
            if (texts_sent % 9 == 8) begin
                // withdraw the last item before waiting for the queue to empty
                @(negedge i_clk);
                in_valid = 1'b0;
                while (norm_due_q.size() != 0) @(posedge i_clk);
            end
            send_text();
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        drain = 0;
        while (norm_due_q.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (16) @(posedge i_clk);
        if (norm_due_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, norm_due_q.size());
            fails++;
        end
        $display("Covered %0d texts and %0d items; %0d results checked, %0d errors, %0d ends.",
                 texts_sent, items_sent, results_seen, errors_seen, ends_seen);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/astn_pkg.sv
rtl/core/assembly_source_text_normalizer_core.sv
tb/sv/tb_assembly_source_text_normalizer_core.sv
